@@ hdl/pixel_dither_threshold_bayer_fs_macros.svh @@
// Assertion helpers shared by the ditherer modules.
`ifndef PIXEL_DITHER_THRESHOLD_BAYER_FS_MACROS_SVH
`define PIXEL_DITHER_THRESHOLD_BAYER_FS_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define PDTB_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
	else $error("pdtb check failed");

// Consequent checked at the edge after the antecedent.
`define PDTB_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error("pdtb check failed");

`endif

@@ hdl/pdtb_pkg.sv @@
`default_nettype none
package pdtb_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS = 128;
	localparam int ERROR_WIDTH = 16;

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);

	localparam int PIX_W = 14;
	localparam int SH_W = ERROR_WIDTH + 2;
	localparam int SUM_W = ERROR_WIDTH + 3;
	localparam int V_W = ERROR_WIDTH + 3;
	localparam int P_W = V_W + 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [V_W-1:0] FLOYD_HALF = V_W'(2048);
	localparam logic signed [V_W-1:0] FLOYD_FULL = V_W'(4096);

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_BAYER = 2'd1;
	localparam logic [1:0] MODE_FLOYD = 2'd2;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;
	localparam logic [1:0] REG_THRESHOLD = 2'd3;

	localparam logic [63:0] BAYER_TAB = 64'h5D7F_91B3_6E4C_A280;

	typedef struct packed {
		logic [7:0] grid_columns;
		logic [7:0] grid_rows;
		logic [1:0] dither_mode;
		logic [7:0] level_threshold;
	} cfg_t;

	typedef struct packed {
		logic floyd;
		logic first;
		logic row_zero;
		logic simple_dot;
		logic frame_end;
		logic [COL_W-1:0] col;
		logic [6:0] row_out;
		logic signed [PIX_W-1:0] pix_term;
	} item_t;

	function automatic logic signed [ERROR_WIDTH-1:0] sat_err(
		input logic signed [SUM_W-1:0] s
	);
		logic signed [ERROR_WIDTH-1:0] hi;
		logic signed [ERROR_WIDTH-1:0] lo;
		logic signed [ERROR_WIDTH-1:0] r;
		hi = {1'b0, {(ERROR_WIDTH - 1){1'b1}}};
		lo = {1'b1, {(ERROR_WIDTH - 1){1'b0}}};
		if (s > SUM_W'(hi)) begin
			r = hi;
		end else if (s < SUM_W'(lo)) begin
			r = lo;
		end else begin
			r = ERROR_WIDTH'(s);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/pixel_dither_threshold_bayer_fs.sv @@
// Pixel ditherer: one 8-bit luma pixel in, one dot bit out with its column, row and an
// end-of-frame mark, in plain threshold, 4x4 ordered or serpentine error-diffusion mode.
// A pixel is taken every cycle while pixel_stall is low; its dot passes the queue, stage 1
// and the output register. The front counts columns and rows and classifies each pixel
// into a four-entry queue; the back runs the error-row read-modify-write against a one-row
// memory of MAX_COLUMNS entries, forwarding the running column errors from pixel to pixel, and
// that loop sets the rate of one pixel per cycle when dot_stall is low. The row memory needs no
// clearing pass. Any configuration write restarts the frame at row 0, column 0.
`default_nettype none
module pixel_dither_threshold_bayer_fs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       pixel_valid,
	output logic            pixel_stall,
	input  wire logic [7:0] luma,
	output logic            dot_valid,
	input  wire logic       dot_stall,
	output logic            dot_bit,
	output logic [6:0]      dot_column,
	output logic [6:0]      dot_row,
	output logic            frame_end
);
	import pdtb_pkg::*;

	cfg_t cfg_q;
	logic push;
	item_t push_item;
	logic full;
	logic pop;
	item_t head;
	logic nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_columns <= 8'd16;
			cfg_q.grid_rows <= 8'd16;
			cfg_q.dither_mode <= MODE_PLAIN;
			cfg_q.level_threshold <= 8'd128;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COLUMNS: cfg_q.grid_columns <= cfg_data;
				REG_ROWS: cfg_q.grid_rows <= cfg_data;
				REG_MODE: cfg_q.dither_mode <= cfg_data[1:0];
				REG_THRESHOLD: cfg_q.level_threshold <= cfg_data;
			endcase
		end
	end

	pdtb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.restart     (cfg_write),
		.luma        (luma),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.push        (push),
		.push_item   (push_item),
		.full        (full)
	);

	pdtb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.nonempty  (nonempty)
	);

	pdtb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.nonempty   (nonempty),
		.pop        (pop),
		.dot_valid  (dot_valid),
		.dot_stall  (dot_stall),
		.dot_bit    (dot_bit),
		.dot_column (dot_column),
		.dot_row    (dot_row),
		.frame_end  (frame_end)
	);

endmodule
`default_nettype wire

@@ hdl/pdtb_front.sv @@
`default_nettype none
module pdtb_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pdtb_pkg::cfg_t cfg,
	input  wire logic           restart,
	input  wire logic [7:0]     luma,
	input  wire logic           pixel_valid,
	output logic                pixel_stall,
	output logic                push,
	output pdtb_pkg::item_t     push_item,
	input  wire logic           full
);
	import pdtb_pkg::*;

	logic [COL_W-1:0] k_q;
	logic [ROW_W-1:0] r_q;
	logic [CNT_W-1:0] ncol;
	logic [RCNT_W-1:0] nrow;
	logic last_in_row;
	logic last_row;
	logic floyd;
	logic bayer;
	logic [3:0] bval;
	logic signed [10:0] bayer_lim;
	logic simple_dot;
	logic [COL_W-1:0] col;

	assign pixel_stall = full;
	assign push = pixel_valid && !full;

	always_comb begin
		if (cfg.grid_columns == 8'd0) begin
			ncol = CNT_W'(1);
		end else if (32'(cfg.grid_columns) > 32'(MAX_COLUMNS)) begin
			ncol = CNT_W'(MAX_COLUMNS);
		end else begin
			ncol = CNT_W'(cfg.grid_columns);
		end
		if (cfg.grid_rows == 8'd0) begin
			nrow = RCNT_W'(1);
		end else if (32'(cfg.grid_rows) > 32'(MAX_ROWS)) begin
			nrow = RCNT_W'(MAX_ROWS);
		end else begin
			nrow = RCNT_W'(cfg.grid_rows);
		end
	end

	always_comb begin
		last_in_row = (CNT_W'(k_q) + CNT_W'(1)) == ncol;
		last_row = (RCNT_W'(r_q) + RCNT_W'(1)) == nrow;
		floyd = cfg.dither_mode == MODE_FLOYD;
		bayer = cfg.dither_mode == MODE_BAYER;
		bval = BAYER_TAB[{r_q[1:0], k_q[1:0], 2'b00} +: 4];
		bayer_lim = $signed({3'b000, cfg.level_threshold}) + $signed({3'b000, bval, 4'b0000})
			- 11'sd120;
		if (bayer) begin
			simple_dot = $signed({3'b000, luma}) >= bayer_lim;
		end else begin
			simple_dot = luma >= cfg.level_threshold;
		end
		if (floyd && r_q[0]) begin
			col = COL_W'(ncol - CNT_W'(1) - CNT_W'(k_q));
		end else begin
			col = k_q;
		end
	end

	always_comb begin
		push_item.floyd = floyd;
		push_item.first = k_q == '0;
		push_item.row_zero = r_q == '0;
		push_item.simple_dot = simple_dot;
		push_item.frame_end = last_in_row && last_row;
		push_item.col = col;
		push_item.row_out = 7'(r_q);
		push_item.pix_term = $signed({2'b00, luma, 4'b0000}) + 14'sd2048
			- $signed({2'b00, cfg.level_threshold, 4'b0000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			r_q <= '0;
		end else if (restart) begin
			k_q <= '0;
			r_q <= '0;
		end else if (push) begin
			if (last_in_row) begin
				k_q <= '0;
				r_q <= last_row ? '0 : r_q + ROW_W'(1);
			end else begin
				k_q <= k_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/pdtb_queue.sv @@
`default_nettype none
`include "pixel_dither_threshold_bayer_fs_macros.svh"
module pdtb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pdtb_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output pdtb_pkg::item_t      head,
	output logic                 nonempty
);
	import pdtb_pkg::*;

	item_t entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`PDTB_ASSERT_NOW(a_push_has_room, clk, arst_n, push, !full)
	`PDTB_ASSERT_NEXT(a_fill_counts, clk, arst_n, push && !pop,
		count_q == $past(count_q) + QCNT_W'(1))

endmodule
`default_nettype wire

@@ hdl/pdtb_back.sv @@
`default_nettype none
`include "pixel_dither_threshold_bayer_fs_macros.svh"
module pdtb_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pdtb_pkg::item_t head,
	input  wire logic            nonempty,
	output logic                 pop,
	output logic                 dot_valid,
	input  wire logic            dot_stall,
	output logic                 dot_bit,
	output logic [6:0]           dot_column,
	output logic [6:0]           dot_row,
	output logic                 frame_end
);
	import pdtb_pkg::*;

	logic signed [ERROR_WIDTH-1:0] err_mem [MAX_COLUMNS];

	item_t item_s1;
	logic valid_s1;
	logic signed [ERROR_WIDTH-1:0] rd_s1;

	logic signed [SH_W-1:0] carry_q;
	logic signed [ERROR_WIDTH-1:0] accp_q;
	logic signed [ERROR_WIDTH-1:0] accc_q;
	logic [COL_W-1:0] prevcol_q;

	logic out_valid_q;
	logic dot_bit_q;
	logic [6:0] dot_column_q;
	logic [6:0] dot_row_q;
	logic frame_end_q;

	logic adv;
	logic mem_we;
	logic signed [ERROR_WIDTH-1:0] base;
	logic signed [ERROR_WIDTH-1:0] this_val;
	logic signed [ERROR_WIDTH-1:0] accc_eff;
	logic signed [V_W-1:0] v;
	logic dot_f;
	logic signed [V_W-1:0] err;
	logic signed [P_W-1:0] err_x;
	logic signed [P_W-1:0] e7;
	logic signed [P_W-1:0] e5;
	logic signed [P_W-1:0] e3;
	logic signed [SH_W-1:0] s7;
	logic signed [SH_W-1:0] s5;
	logic signed [SH_W-1:0] s3;
	logic signed [SH_W-1:0] s1;
	logic signed [ERROR_WIDTH-1:0] final_prev;
	logic signed [ERROR_WIDTH-1:0] new_accp;
	logic signed [ERROR_WIDTH-1:0] new_accc;

	assign adv = valid_s1 && (!out_valid_q || !dot_stall);
	assign pop = nonempty && (!valid_s1 || adv);
	assign mem_we = adv && item_s1.floyd && !item_s1.first;

	always_comb begin
		if (item_s1.row_zero) begin
			base = '0;
		end else if (item_s1.first) begin
			base = accp_q;
		end else begin
			base = rd_s1;
		end
		if (item_s1.first) begin
			this_val = base;
			accc_eff = '0;
		end else begin
			this_val = sat_err(SUM_W'(base) + SUM_W'(carry_q));
			accc_eff = accc_q;
		end
		v = V_W'($signed(item_s1.pix_term)) + V_W'(this_val);
		dot_f = v >= FLOYD_HALF;
		err = dot_f ? v - FLOYD_FULL : v;
		err_x = P_W'(err);
		e7 = (err_x <<< 3) - err_x;
		e5 = (err_x <<< 2) + err_x;
		e3 = (err_x <<< 1) + err_x;
		s7 = SH_W'(e7 >>> 4);
		s5 = SH_W'(e5 >>> 4);
		s3 = SH_W'(e3 >>> 4);
		s1 = SH_W'(err >>> 4);
		final_prev = sat_err(SUM_W'(accp_q) + SUM_W'(s3));
		new_accp = sat_err(SUM_W'(accc_eff) + SUM_W'(s5));
		new_accc = sat_err(SUM_W'(s1));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			err_mem[prevcol_q] <= final_prev;
		end
		if (pop) begin
			rd_s1 <= err_mem[head.col];
			item_s1 <= head;
		end
		if (adv) begin
			carry_q <= s7;
			accp_q <= new_accp;
			accc_q <= new_accc;
			prevcol_q <= item_s1.col;
			dot_bit_q <= item_s1.floyd ? dot_f : item_s1.simple_dot;
			dot_column_q <= 7'(item_s1.col);
			dot_row_q <= item_s1.row_out;
			frame_end_q <= item_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!dot_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dot_valid = out_valid_q;
	assign dot_bit = dot_bit_q;
	assign dot_column = dot_column_q;
	assign dot_row = dot_row_q;
	assign frame_end = frame_end_q;

	`PDTB_ASSERT_NEXT(a_pop_loads_stage, clk, arst_n, pop, valid_s1)
	`PDTB_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(item_s1.col))
	`PDTB_ASSERT_NOW(a_no_row_collision, clk, arst_n,
		pop && mem_we && head.floyd && !head.first, head.col != prevcol_q)

endmodule
`default_nettype wire
